// ===== sv/clle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cursor linked list engine.
// No dependencies; every file except clle_ram imports this package.
package clle_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int LEN_W     = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_FREE,
    OP_TAKE_FREE,
    OP_WALK_RD,
    OP_WALK_STEP,
    OP_INS_LINK,
    OP_INS_COMMIT,
    OP_DEL_J,
    OP_DEL_LINK,
    OP_DEL_COMMIT,
    OP_DUMP_RD
  } dp_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DONE,
    OUT_ITEM
  } out_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_FREE,
    S_INS_TAKE,
    S_WALK_ISSUE,
    S_WALK,
    S_INS_LINK,
    S_INS_COMMIT,
    S_DEL_J,
    S_DEL_LINK,
    S_DEL_COMMIT,
    S_DUMP_HEAD,
    S_DUMP_FIRST,
    S_DUMP_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t   op;
    out_sel_t out_sel;
    status_t  status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic ins_bad;
    logic del_bad;
    logic empty;
    logic steps_zero;
    logic dump_last;
  } dp_stat_t;

endpackage

// ===== sv/clle_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No package dependency.
module clle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/clle_dp.sv =====
`timescale 1ns / 1ps
// Datapath: link and value stores, walk cursor, free head, element count
// and result registers. Depends on clle_pkg and clle_ram.
module clle_dp
  import clle_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic [STAT_W-1:0]       out_status,
  output logic signed [VAL_W-1:0] out_item_value,
  output logic [LEN_W-1:0]        out_list_length,
  output logic                    out_last
);

  localparam int IW   = $clog2(SLOTS);
  localparam int CMPW = POS_W + 1;

  logic [IW-1:0]           cur_r, cur_nxt;
  logic [IW-1:0]           aux_r, aux_nxt;
  logic [IW-1:0]           steps_r, steps_nxt;
  logic [IW-1:0]           remain_r, remain_nxt;
  logic [IW-1:0]           free_head_r, free_head_nxt;
  logic [IW-1:0]           count_r, count_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [SLOTS-1:0]        lvld_r, lvld_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]           rd_addr_r, rd_addr_nxt;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic signed [VAL_W-1:0] out_item_r;
  logic [LEN_W-1:0]        out_len_r;
  logic                    out_last_r;

  logic                    link_we, link_re;
  logic [IW-1:0]           link_waddr, link_wdata, link_raddr, link_q, link_rd;
  logic                    vs_we, vs_re;
  logic [IW-1:0]           vs_raddr;
  logic [VAL_W-1:0]        vs_q;

  logic [CMPW-1:0]         pos_ext, cnt_ext;

  clle_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  clle_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (vs_we),
    .waddr (aux_r),
    .wdata (val_r),
    .re    (vs_re),
    .raddr (vs_raddr),
    .rdata (vs_q)
  );

  // unwritten link entries read as their reset chain value
  always_comb begin
    if (rd_vld_r) begin
      link_rd = link_q;
    end else if (rd_addr_r == IW'(SLOTS - 1)) begin
      link_rd = '0;
    end else begin
      link_rd = rd_addr_r + IW'(1);
    end
  end

  assign pos_ext         = CMPW'(in_position);
  assign cnt_ext         = CMPW'(count_r);
  assign stat.full       = (count_r == IW'(SLOTS - 2));
  assign stat.ins_bad    = (in_position == '0) || (pos_ext > cnt_ext + CMPW'(1));
  assign stat.del_bad    = (in_position == '0) || (pos_ext > cnt_ext);
  assign stat.empty      = (count_r == '0);
  assign stat.steps_zero = (steps_r == '0);
  assign stat.dump_last  = (remain_r == IW'(1));

  always_comb begin
    cur_nxt       = cur_r;
    aux_nxt       = aux_r;
    steps_nxt     = steps_r;
    remain_nxt    = remain_r;
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    val_nxt       = val_r;
    lvld_nxt      = lvld_r;
    link_we       = 1'b0;
    link_waddr    = cur_r;
    link_wdata    = aux_r;
    link_re       = 1'b0;
    link_raddr    = cur_r;
    vs_we         = 1'b0;
    vs_re         = 1'b0;
    vs_raddr      = link_rd;
    case (cmd.op)
      OP_LOAD: begin
        val_nxt    = in_value;
        steps_nxt  = IW'(in_position - POS_W'(1));
        cur_nxt    = IW'(SLOTS - 1);
        remain_nxt = count_r;
      end
      OP_RD_FREE: begin
        link_re    = 1'b1;
        link_raddr = free_head_r;
        aux_nxt    = free_head_r;
      end
      OP_TAKE_FREE: begin
        free_head_nxt = link_rd;
      end
      OP_WALK_RD: begin
        link_re    = 1'b1;
        link_raddr = cur_r;
      end
      OP_WALK_STEP: begin
        cur_nxt    = link_rd;
        steps_nxt  = steps_r - IW'(1);
        link_re    = 1'b1;
        link_raddr = link_rd;
      end
      OP_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = aux_r;
        link_wdata = link_rd;
      end
      OP_INS_COMMIT: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = aux_r;
        vs_we      = 1'b1;
        count_nxt  = count_r + IW'(1);
      end
      OP_DEL_J: begin
        aux_nxt    = link_rd;
        link_re    = 1'b1;
        link_raddr = link_rd;
      end
      OP_DEL_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = link_rd;
      end
      OP_DEL_COMMIT: begin
        link_we       = 1'b1;
        link_waddr    = aux_r;
        link_wdata    = free_head_r;
        free_head_nxt = aux_r;
        count_nxt     = count_r - IW'(1);
      end
      OP_DUMP_RD: begin
        link_re    = 1'b1;
        link_raddr = link_rd;
        vs_re      = 1'b1;
      end
      default: begin
      end
    endcase
    if (link_we) begin
      lvld_nxt[link_waddr] = 1'b1;
    end
    if (cmd.out_sel == OUT_ITEM) begin
      remain_nxt = remain_r - IW'(1);
    end
  end

  assign rd_vld_nxt  = link_re ? lvld_r[link_raddr] : rd_vld_r;
  assign rd_addr_nxt = link_re ? link_raddr : rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= IW'(1);
      count_r     <= '0;
      lvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      lvld_r      <= lvld_nxt;
      out_valid_r <= (cmd.out_sel != OUT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    aux_r     <= aux_nxt;
    steps_r   <= steps_nxt;
    remain_r  <= remain_nxt;
    val_r     <= val_nxt;
    rd_vld_r  <= rd_vld_nxt;
    rd_addr_r <= rd_addr_nxt;
    if (cmd.out_sel == OUT_ITEM) begin
      out_status_r <= ST_OK;
      out_item_r   <= vs_q;
      out_last_r   <= stat.dump_last;
    end else begin
      out_status_r <= cmd.status;
      out_item_r   <= '0;
      out_last_r   <= 1'b1;
    end
    out_len_r <= LEN_W'(count_nxt);
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_value  = out_item_r;
  assign out_list_length = out_len_r;
  assign out_last        = out_last_r;

endmodule

// ===== sv/clle_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences insert, delete and dump as datapath micro-ops.
// Depends on clle_pkg.
module clle_ctrl
  import clle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd,
  output logic              busy
);

  state_t state_r, state_nxt;
  logic   del_r, del_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      del_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      del_r   <= del_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    del_nxt     = del_r;
    cmd.op      = OP_NONE;
    cmd.out_sel = OUT_NONE;
    cmd.status  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (kind_t'(in_kind))
            KIND_INSERT: begin
              if (stat.full) begin
                cmd.out_sel = OUT_DONE;
                cmd.status  = ST_FULL;
              end else if (stat.ins_bad) begin
                cmd.out_sel = OUT_DONE;
                cmd.status  = ST_RANGE;
              end else begin
                cmd.op    = OP_LOAD;
                del_nxt   = 1'b0;
                state_nxt = S_INS_FREE;
              end
            end
            KIND_DELETE: begin
              if (stat.del_bad) begin
                cmd.out_sel = OUT_DONE;
                cmd.status  = ST_RANGE;
              end else begin
                cmd.op    = OP_LOAD;
                del_nxt   = 1'b1;
                state_nxt = S_WALK_ISSUE;
              end
            end
            KIND_DUMP: begin
              if (stat.empty) begin
                cmd.out_sel = OUT_DONE;
                cmd.status  = ST_EMPTY;
              end else begin
                cmd.op    = OP_LOAD;
                state_nxt = S_DUMP_HEAD;
              end
            end
            default: begin
              cmd.out_sel = OUT_DONE;
            end
          endcase
        end
      end
      S_INS_FREE: begin
        cmd.op    = OP_RD_FREE;
        state_nxt = S_INS_TAKE;
      end
      S_INS_TAKE: begin
        cmd.op    = OP_TAKE_FREE;
        state_nxt = S_WALK_ISSUE;
      end
      S_WALK_ISSUE: begin
        cmd.op    = OP_WALK_RD;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (!stat.steps_zero) begin
          cmd.op = OP_WALK_STEP;
        end else if (del_r) begin
          state_nxt = S_DEL_J;
        end else begin
          state_nxt = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        cmd.op    = OP_INS_LINK;
        state_nxt = S_INS_COMMIT;
      end
      S_INS_COMMIT: begin
        cmd.op      = OP_INS_COMMIT;
        cmd.out_sel = OUT_DONE;
        state_nxt   = S_IDLE;
      end
      S_DEL_J: begin
        cmd.op    = OP_DEL_J;
        state_nxt = S_DEL_LINK;
      end
      S_DEL_LINK: begin
        cmd.op    = OP_DEL_LINK;
        state_nxt = S_DEL_COMMIT;
      end
      S_DEL_COMMIT: begin
        cmd.op      = OP_DEL_COMMIT;
        cmd.out_sel = OUT_DONE;
        state_nxt   = S_IDLE;
      end
      S_DUMP_HEAD: begin
        cmd.op    = OP_WALK_RD;
        state_nxt = S_DUMP_FIRST;
      end
      S_DUMP_FIRST: begin
        cmd.op    = OP_DUMP_RD;
        state_nxt = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        cmd.op      = OP_DUMP_RD;
        cmd.out_sel = OUT_ITEM;
        if (stat.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/cursor_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the cursor linked list engine: controller plus datapath.
// Depends on clle_pkg, clle_ctrl, clle_dp and clle_ram.
//
// A transaction is taken when start is high and busy is low. Results come
// out on out_valid, one cycle each, and cannot be held off by the receiver.
// Errors and kind 3 answer in the cycle after the transaction, with no busy time.
// The link chain lives in a memory with registered read, and the walk takes
// one link read per hop. Busy stays high while an insert takes a free slot,
// walks, links and commits, while a delete walks, links and commits, and
// while a dump streams one element per cycle. Link memory entries never
// written read back their reset chain through per-entry valid bits, so no
// clearing pass follows reset.
module cursor_linked_list_engine_core
  import clle_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [VAL_W-1:0]  out_item_value,
  output logic [LEN_W-1:0]         out_list_length,
  output logic                     out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  clle_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  clle_dp #(.SLOTS(SLOTS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_position     (in_position),
    .in_value        (in_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_item_value  (out_item_value),
    .out_list_length (out_list_length),
    .out_last        (out_last)
  );

  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction produced neither work nor result");

  a_dump_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final dump result while idle");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_list_length <= LEN_W'(SLOTS - 2))
    else $error("list length exceeds capacity");

  a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_item_value == '0 && out_last)
    else $error("error result carries an item or is not final");

endmodule

// ===== verif/clle_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cursor linked list engine: keeps its own copy of the list, free chain
// and element count, and compares every result with the oldest predicted one.
// Depends on clle_pkg; instantiated beside the block by tb_cursor_linked_list_engine_core.
module clle_checker
  import clle_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic                     out_valid,
  input  logic [STAT_W-1:0]        out_status,
  input  logic signed [VAL_W-1:0]  out_item_value,
  input  logic [LEN_W-1:0]         out_list_length,
  input  logic                     out_last,
  output int                       fail_count,
  output int                       pending_replies,
  output int                       replies_checked
);

  localparam int SLOTS = SLOTS_DEF;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] item_value;
    logic [LEN_W-1:0]        list_length;
    logic                    last;
  } list_reply_t;

  logic [POS_W-1:0] link_next  [SLOTS];
  logic [VAL_W-1:0] slot_value [SLOTS];
  int unsigned      elem_count;
  list_reply_t      expected_list_replies [$];
  list_reply_t      oldest;

  initial begin
    fail_count      = 0;
    pending_replies = 0;
    replies_checked = 0;
  end

  task automatic clear_list();
    for (int i = 0; i < SLOTS; i++) begin
      link_next[i]  = POS_W'(i + 1);
      slot_value[i] = '0;
    end
    link_next[SLOTS-1] = '0;
    elem_count = 0;
    expected_list_replies.delete();
  endtask

  // Follow the data chain from its head slot for the given number of hops.
  function automatic logic [POS_W-1:0] hop(input int unsigned steps);
    logic [POS_W-1:0] slot;
    slot = POS_W'(SLOTS - 1);
    for (int unsigned i = 0; i < steps; i++) slot = link_next[slot];
    return slot;
  endfunction

  task automatic push_reply(input status_t st, input logic [VAL_W-1:0] v, input logic l);
    list_reply_t r;
    r.status      = st;
    r.item_value  = v;
    r.list_length = LEN_W'(elem_count);
    r.last        = l;
    expected_list_replies.push_back(r);
  endtask

  task automatic apply_list_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
    logic [POS_W-1:0] taken;
    logic [POS_W-1:0] prev;
    logic [POS_W-1:0] cur;
    int unsigned      p;
    p = pos;
    case (kind_t'(kind))
      KIND_INSERT: begin
        if (elem_count >= SLOTS - 2) push_reply(ST_FULL, '0, 1'b1);
        else if (p < 1 || p > elem_count + 1) push_reply(ST_RANGE, '0, 1'b1);
        else begin
          taken            = link_next[0];
          link_next[0]     = link_next[taken];
          prev             = hop(p - 1);
          slot_value[taken] = val;
          link_next[taken] = link_next[prev];
          link_next[prev]  = taken;
          elem_count++;
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      KIND_DELETE: begin
        if (p < 1 || p > elem_count) push_reply(ST_RANGE, '0, 1'b1);
        else begin
          prev            = hop(p - 1);
          cur             = link_next[prev];
          link_next[prev] = link_next[cur];
          link_next[cur]  = link_next[0];
          link_next[0]    = cur;
          elem_count--;
          push_reply(ST_OK, '0, 1'b1);
        end
      end
      KIND_DUMP: begin
        if (elem_count == 0) push_reply(ST_EMPTY, '0, 1'b1);
        else begin
          cur = link_next[SLOTS-1];
          for (int unsigned i = 0; i < elem_count; i++) begin
            push_reply(ST_OK, slot_value[cur], (i + 1 == elem_count));
            cur = link_next[cur];
          end
        end
      end
      default: push_reply(ST_OK, '0, 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_list();
    end else begin
      if (out_valid) begin
        if (expected_list_replies.size() == 0) begin
          $error("result with nothing expected: status %0d value %0d length %0d last %0d",
                 out_status, out_item_value, out_list_length, out_last);
          fail_count++;
        end else begin
          oldest = expected_list_replies.pop_front();
          replies_checked++;
          if (out_status !== oldest.status) begin
            $error("out_status: expected %0d, got %0d", oldest.status, out_status);
            fail_count++;
          end
          if (out_item_value !== oldest.item_value) begin
            $error("out_item_value: expected %0d, got %0d", oldest.item_value, out_item_value);
            fail_count++;
          end
          if (out_list_length !== oldest.list_length) begin
            $error("out_list_length: expected %0d, got %0d", oldest.list_length,
                   out_list_length);
            fail_count++;
          end
          if (out_last !== oldest.last) begin
            $error("out_last: expected %0d, got %0d", oldest.last, out_last);
            fail_count++;
          end
        end
      end
      if (start && !busy) apply_list_op(in_kind, in_position, in_value);
    end
    pending_replies = expected_list_replies.size();
  end

endmodule

// ===== verif/tb_cursor_linked_list_engine_core.sv =====
`timescale 1ns / 1ps
// Testbench top for cursor_linked_list_engine_core: drives insert, delete, dump and spare-kind
// transactions with random gaps and gives the verdict. Depends on clle_pkg, clle_checker and the DUT.
module tb_cursor_linked_list_engine_core;
  import clle_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int MAX_LEN = SLOTS_DEF - 2;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [KIND_W-1:0]       in_kind;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic signed [VAL_W-1:0] out_item_value;
  logic [LEN_W-1:0]        out_list_length;
  logic                    out_last;

  int fail_count;
  int pending_replies;
  int replies_checked;

  int  list_len;
  int  peak_len;
  int  n_insert;
  int  n_delete;
  int  n_dump;
  int  n_spare;
  int  n_full;
  bit  gaps_on;

  cursor_linked_list_engine_core #(.SLOTS(SLOTS_DEF)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_item_value  (out_item_value),
    .out_list_length (out_list_length),
    .out_last        (out_last)
  );

  clle_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_item_value  (out_item_value),
    .out_list_length (out_list_length),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_replies (pending_replies),
    .replies_checked (replies_checked)
  );

  always #4 clk = ~clk;

  // Enter and leave at a falling edge; hold the transaction until start meets busy low.
  task automatic issue_op(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                          input logic [VAL_W-1:0] v);
    while (gaps_on && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_kind     <= k;
    in_position <= p;
    in_value    <= v;
    do @(posedge clk); while (busy);
    case (kind_t'(k))
      KIND_INSERT: begin
        n_insert++;
        if (list_len >= MAX_LEN) n_full++;
        else if (p >= 1 && p <= list_len + 1) list_len++;
      end
      KIND_DELETE: begin
        n_delete++;
        if (p >= 1 && p <= list_len) list_len--;
      end
      KIND_DUMP: n_dump++;
      default:   n_spare++;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    @(negedge clk);
  endtask

  initial begin
    int unsigned r;
    bit          grow;
    logic [VAL_W-1:0] v;
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_kind     = KIND_INSERT;
    in_position = '0;
    in_value    = '0;
    list_len    = 0;
    peak_len    = 0;
    n_insert    = 0;
    n_delete    = 0;
    n_dump      = 0;
    n_spare     = 0;
    n_full      = 0;
    gaps_on     = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue_op(KIND_DUMP,   6'd0,  32'h0000_0000);
    issue_op(KIND_DELETE, 6'd1,  32'h0000_0000);
    issue_op(KIND_DELETE, 6'd0,  32'hFFFF_FFFF);
    issue_op(KIND_INSERT, 6'd0,  32'h1234_5678);
    issue_op(KIND_INSERT, 6'd2,  32'h1234_5678);
    issue_op(KIND_INSERT, 6'd1,  32'h8000_0000);
    issue_op(KIND_INSERT, 6'd2,  32'h7FFF_FFFF);
    issue_op(KIND_INSERT, 6'd1,  32'h0000_0000);
    issue_op(KIND_INSERT, 6'd2,  32'hFFFF_FFFF);
    issue_op(KIND_INSERT, 6'd5,  32'h5555_5555);
    issue_op(KIND_INSERT, 6'd63, 32'h0BAD_0BAD);
    issue_op(KIND_SPARE,  6'd63, 32'hFFFF_FFFF);
    issue_op(KIND_DUMP,   6'd63, 32'hFFFF_FFFF);
    issue_op(KIND_DELETE, 6'd6,  32'h0000_0000);
    issue_op(KIND_DELETE, 6'd63, 32'h0000_0000);
    issue_op(KIND_DELETE, 6'd3,  32'h0000_0000);
    issue_op(KIND_DELETE, 6'd1,  32'h0000_0000);
    issue_op(KIND_DELETE, 6'd3,  32'h0000_0000);
    issue_op(KIND_INSERT, 6'd1,  32'hAAAA_AAAA);
    issue_op(KIND_DUMP,   6'd0,  32'h0000_0000);
    issue_op(KIND_SPARE,  6'd0,  32'h0000_0000);

    // Alternate growth and drain phases, two of each.
    for (int n = 0; n < 310; n++) begin
      grow    = (n < 100) || (n >= 160 && n < 260);
      gaps_on = !(n >= 120 && n < 200);
      r       = $urandom_range(99);
      v       = $urandom;
      if ($urandom_range(15) == 0) v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (r < 6) begin
        issue_op(KIND_DUMP, 6'($urandom_range(63)), v);
      end else if (r < 8) begin
        issue_op(KIND_SPARE, 6'($urandom_range(63)), v);
      end else if (r < 14) begin
        issue_op($urandom_range(1) ? KIND_INSERT : KIND_DELETE, 6'($urandom_range(63)), v);
      end else if (grow ? (r < 86) : (r < 30)) begin
        if (list_len >= MAX_LEN) issue_op(KIND_INSERT, 6'($urandom_range(63)), v);
        else issue_op(KIND_INSERT, 6'($urandom_range(list_len + 1, 1)), v);
      end else begin
        if (list_len == 0) issue_op(KIND_DELETE, 6'($urandom_range(63)), v);
        else issue_op(KIND_DELETE, 6'($urandom_range(list_len, 1)), v);
      end
    end

    start <= 1'b0;
    while (pending_replies != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("covered %0d inserts (%0d on a full list), %0d deletes, %0d dumps, %0d spare",
             n_insert, n_full, n_delete, n_dump, n_spare);
    $display("compared %0d results, list length peaked at %0d", replies_checked, peak_len);
    if (fail_count == 0 && pending_replies == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
